[sv/core_slot_allocator_unit_defines.svh]
// Assertion macros shared by the slot allocator RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef CORE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define CORE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("slot allocator check failed");
`define CSA_NEVER(label, clk, rst, expr) \
   `CSA_ASSERT(label, clk, rst, !(expr))
`else
`define CSA_ASSERT(label, clk, rst, prop)
`define CSA_NEVER(label, clk, rst, expr)
`endif
`endif

[sv/csa_pkg.sv]
// Package for the slot allocator: widths, operation and strategy codes,
// register map. No dependencies.
package csa_pkg;

   localparam int MAX_CORES  = 64;
   localparam int SLOT_W     = $clog2(MAX_CORES);
   localparam int COUNT_W    = $clog2(MAX_CORES + 1);
   localparam int OP_W       = 1;
   localparam int STRAT_W    = 2;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_LSB = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [STRAT_W-1:0] {
      STRAT_ROUND_ROBIN = 2'd0,
      STRAT_FIRST_FREE  = 2'd1,
      STRAT_LOCALITY    = 2'd2
   } strategy_type;

   typedef enum logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] {
      REG_CORE_COUNT = 1'b0,
      REG_LOCAL_MASK = 1'b1
   } csr_index_type;

   localparam logic [COUNT_W-1:0]   CORE_COUNT_RESET = COUNT_W'(MAX_CORES);
   localparam logic [MAX_CORES-1:0] LOCAL_MASK_RESET = '1;

endpackage

[sv/csa_req_if.sv]
// Request channel of the slot allocator: valid/ready plus request fields.
// Depends on csa_pkg.
interface csa_req_if import csa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [STRAT_W-1:0] strategy;
   logic [SLOT_W-1:0]  slot_index;

   modport source (output valid, output op, output strategy, output slot_index,
                   input ready);
   modport sink   (input valid, input op, input strategy, input slot_index,
                   output ready);
endinterface

[sv/csa_rsp_if.sv]
// Response channel of the slot allocator: valid/ready plus result fields.
// Depends on csa_pkg.
interface csa_rsp_if import csa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              ok;
   logic [SLOT_W-1:0] granted_slot;

   modport source (output valid, output ok, output granted_slot, input ready);
   modport sink   (input valid, input ok, input granted_slot, output ready);
endinterface

[sv/core_slot_allocator_unit.sv]
// Slot allocator top level: busy bitmap, round-robin pointer, APB registers.
// Depends on csa_pkg, csa_req_if, csa_rsp_if and the assertion macro header.
//
// Each request allocates or releases one slot out of up to MAX_CORES and
// gives exactly one response. The block sustains one request per clock
// while responses are taken: a request is captured in an input register,
// decided by a single 64-bit find-lowest-set over the candidate free map,
// and written to a response register. The busy map and round-robin pointer
// update at the same edge that loads the response register, so the next
// request already sees them. The response register frees the input side
// while a response waits; a stalled response stalls decisions and then the
// request channel. Registers: core_count at byte 0x0 (0 acts as 1, values
// above MAX_CORES saturate), local_mask at byte 0x8; write them only while
// no request is in flight. The busy map clears at reset.
`include "core_slot_allocator_unit_defines.svh"

module core_slot_allocator_unit import csa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   csa_req_if.sink               req_if,
   csa_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // lowest set bit; caller checks for an empty vector
   function automatic logic [SLOT_W-1:0] lowest_set(input logic [MAX_CORES-1:0] v);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = MAX_CORES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

   // configuration registers
   logic [COUNT_W-1:0]   core_count_ff, core_count_in;
   logic [MAX_CORES-1:0] local_mask_ff, local_mask_in;

   // allocator state
   logic [MAX_CORES-1:0] busy_map_ff, busy_map_in;
   logic [SLOT_W-1:0]    rr_ptr_ff, rr_ptr_in;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [OP_W-1:0]      in_op_ff;
   logic [STRAT_W-1:0]   in_strategy_ff;
   logic [SLOT_W-1:0]    in_slot_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   logic                 csr_write;
   csr_index_type        csr_index;
   logic                 req_fire;
   logic                 stage_go;
   logic [COUNT_W-1:0]   slots_n;
   logic [MAX_CORES-1:0] in_range;
   logic [MAX_CORES-1:0] free_map;
   logic [MAX_CORES-1:0] local_free;
   logic [MAX_CORES-1:0] upper_mask;
   logic [MAX_CORES-1:0] rr_upper;
   logic [MAX_CORES-1:0] candidates;
   logic [SLOT_W-1:0]    rr_start;
   logic [SLOT_W-1:0]    pick;
   logic [COUNT_W-1:0]   pick_next;
   logic                 grant;
   logic                 release_ok;
   logic                 alloc_go;
   logic                 release_go;

   //---------------------------------------------------------------
   // Register port: zero-wait writes in the access phase, decode on
   // the 8-byte register index.
   //---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB]);

   always_comb begin
      core_count_in = core_count_ff;
      local_mask_in = local_mask_ff;
      csr_prdata    = '0;
      case (csr_index)
         REG_CORE_COUNT: begin
            csr_prdata = CSR_DATA_W'(core_count_ff);
            if (csr_write) begin
               core_count_in = csr_pwdata[COUNT_W-1:0];
            end
         end
         REG_LOCAL_MASK: begin
            csr_prdata = CSR_DATA_W'(local_mask_ff);
            if (csr_write) begin
               local_mask_in = csr_pwdata[MAX_CORES-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   //---------------------------------------------------------------
   // Handshakes: the input register advances whenever the response
   // register is empty or being drained.
   //---------------------------------------------------------------
   assign stage_go     = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || stage_go;
   assign req_fire     = req_if.valid && req_if.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (stage_go ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = stage_go ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   //---------------------------------------------------------------
   // Decision logic
   //---------------------------------------------------------------
   // saturate the slot count to 1..MAX_CORES
   always_comb begin
      if (core_count_ff == '0) begin
         slots_n = COUNT_W'(1);
      end else if (core_count_ff > COUNT_W'(MAX_CORES)) begin
         slots_n = COUNT_W'(MAX_CORES);
      end else begin
         slots_n = core_count_ff;
      end
   end

   // round-robin restarts at slot 0 when the pointer is at or past the slot count
   assign rr_start = ({1'b0, rr_ptr_ff} < slots_n) ? rr_ptr_ff : '0;

   always_comb begin
      for (int i = 0; i < MAX_CORES; i++) begin
         in_range[i]   = COUNT_W'(i) < slots_n;
         upper_mask[i] = SLOT_W'(i) >= rr_start;
      end
   end

   assign free_map   = ~busy_map_ff & in_range;
   assign local_free = free_map & local_mask_ff;
   assign rr_upper   = free_map & upper_mask;

   // pick the candidate set per strategy, then one shared encoder
   always_comb begin
      case (strategy_type'(in_strategy_ff))
         STRAT_ROUND_ROBIN: candidates = (rr_upper != '0) ? rr_upper : free_map;
         STRAT_FIRST_FREE:  candidates = free_map;
         STRAT_LOCALITY:    candidates = (local_free != '0) ? local_free : free_map;
         // unused code behaves as locality first
         default:           candidates = (local_free != '0) ? local_free : free_map;
      endcase
   end

   assign pick       = lowest_set(candidates);
   assign grant      = (candidates != '0);
   assign pick_next  = {1'b0, pick} + COUNT_W'(1);
   assign release_ok = ({1'b0, in_slot_ff} < slots_n);

   always_comb begin
      busy_map_in = busy_map_ff;
      rr_ptr_in   = rr_ptr_ff;
      rsp_ok_in   = 1'b0;
      rsp_slot_in = '0;
      if (in_op_ff == OP_RELEASE) begin
         rsp_ok_in = release_ok;
         if (stage_go && release_ok) begin
            busy_map_in[in_slot_ff] = 1'b0;
         end
      end else begin
         rsp_ok_in   = grant;
         rsp_slot_in = grant ? pick : '0;
         if (stage_go && grant) begin
            busy_map_in[pick] = 1'b1;
         end
         if (stage_go && (in_strategy_ff == STRAT_ROUND_ROBIN)) begin
            // leave the pointer just past the grant, or where probing began
            if (!grant) begin
               rr_ptr_in = rr_start;
            end else if (pick_next >= slots_n) begin
               rr_ptr_in = '0;
            end else begin
               rr_ptr_in = pick_next[SLOT_W-1:0];
            end
         end
      end
   end

   //---------------------------------------------------------------
   // Registers
   //---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         core_count_ff <= CORE_COUNT_RESET;
         local_mask_ff <= LOCAL_MASK_RESET;
         busy_map_ff   <= '0;
         rr_ptr_ff     <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         core_count_ff <= core_count_in;
         local_mask_ff <= local_mask_in;
         busy_map_ff   <= busy_map_in;
         rr_ptr_ff     <= rr_ptr_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: input fields load on capture, response fields on decision; hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff       <= req_if.op;
         in_strategy_ff <= req_if.strategy;
         in_slot_ff     <= req_if.slot_index;
      end
      if (stage_go) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_slot_ff <= rsp_slot_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.ok           = rsp_ok_ff;
   assign rsp_if.granted_slot = rsp_slot_ff;

   //---------------------------------------------------------------
   // Checks
   //---------------------------------------------------------------
   assign alloc_go   = stage_go && (in_op_ff == OP_ALLOC) && grant;
   assign release_go = stage_go && (in_op_ff == OP_RELEASE) && release_ok;

   `CSA_ASSERT(a_grant_marks_busy, clock, reset, alloc_go |=> busy_map_ff[$past(pick)])
   `CSA_ASSERT(a_release_clears, clock, reset, release_go |=> !busy_map_ff[$past(in_slot_ff)])
   `CSA_ASSERT(a_grant_in_range, clock, reset, alloc_go |-> ({1'b0, pick} < slots_n))
   `CSA_ASSERT(a_request_held, clock, reset, (in_valid_ff && !stage_go) |=> in_valid_ff)
   `CSA_NEVER(a_fail_slot_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff && (rsp_slot_ff != '0))

endmodule
